// ===== rtl/mlpi_pkg.sv =====
package mlpi_pkg;

    // Request: one weight write or one inference
    typedef struct packed {
        logic               op;
        logic        [10:0] weight_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] obs_0;
        logic signed [15:0] obs_1;
        logic signed [15:0] obs_2;
        logic signed [15:0] obs_3;
        logic signed [15:0] obs_4;
        logic signed [15:0] obs_5;
    } req_t;

    // Response: four clamped actions
    typedef struct packed {
        logic [12:0] action_0;
        logic [12:0] action_1;
        logic [12:0] action_2;
        logic [12:0] action_3;
    } rsp_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_INFER = 1'b1;

    // Layer codes
    localparam logic [1:0] LAYER_ONE = 2'd0;
    localparam logic [1:0] LAYER_TWO = 2'd1;
    localparam logic [1:0] LAYER_OUT = 2'd2;

    localparam int Q_ONE          = 4096;
    localparam int TANH_RANGE     = 16384;
    localparam longint unsigned ONE_Q32       = 64'd4294967296;
    localparam longint unsigned EXP_M1_Q32    = 64'd1580030169;

    // Shift-subtract divide, used only while building the tanh table
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | ((a >> i) & 64'd1);
            if (r >= b) begin
                r = r - b;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // exp(-u/4096) in Q0.32, series for the fraction then whole units
    function automatic longint unsigned exp_neg_q32(int unsigned u);
        int unsigned     whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned val;
        whole = u >> 12;
        frac  = longint'(u & 32'd4095) << 20;
        term  = ONE_Q32;
        pos   = ONE_Q32;
        neg   = 0;
        for (int k = 1; k <= 14; k++) begin
            term = udiv64((term * frac) >> 32, longint'(k));
            if (k % 2 == 1) neg = neg + term;
            else            pos = pos + term;
        end
        val = pos - neg;
        for (int k = 0; k < 8; k++) begin
            if (k < whole) val = (val * EXP_M1_Q32) >> 32;
        end
        return val;
    endfunction

    // tanh at the midpoint of one table bin, Q4.12
    function automatic logic signed [15:0] tanh_entry(int unsigned bin, int unsigned depth);
        longint unsigned q;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        int              mid;
        int unsigned     t;
        int              mag;
        q   = udiv64(longint'(2 * bin + 1) * 16384, longint'(depth));
        mid = -TANH_RANGE + int'(q);
        t   = (mid < 0) ? -mid : mid;
        e   = exp_neg_q32(2 * t);
        num = (ONE_Q32 - e) * 4096;
        den = ONE_Q32 + e;
        mag = int'(udiv64(2 * num + den, 2 * den));
        return (mid < 0) ? 16'(-mag) : 16'(mag);
    endfunction

endpackage

// ===== rtl/mlpi_ram.sv =====
module mlpi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mlp_tanh_policy_inference_unit.sv =====
// Policy network engine: six observations, two tanh hidden layers, four actions.
// Request channel (req_valid/req_stall/req_data): op 0 writes one Q4.12 word into
// the weight memory (W0, B0, W2, B2, WA, BA in that order); op 1 runs inference
// on obs_0..obs_5. Response channel (rsp_valid/rsp_stall/rsp_data) returns one
// item per inference with four actions clamped to 0..4096; writes return none.
// An inference takes one pass of the single MAC over the weight memory read
// port: each neuron is summed with its bias, drained and rounded; a hidden
// neuron is then binned, looked up in the tanh table and written back, an
// output neuron clamped. req_stall is high while an inference runs. A finished
// result sits in the response register; the next request is taken while it
// waits, and a later inference holds at its end until the register frees.
// Reset clears control state only; weights must be written before use, and
// the hidden buffers are rewritten by every inference.
module mlp_tanh_policy_inference_unit
    import mlpi_pkg::*;
#(
    parameter int HIDDEN1          = 32,
    parameter int HIDDEN2          = 32,
    parameter int WEIGHT_DEPTH     = 2048,
    parameter int TANH_TABLE_DEPTH = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int IN_CNT   = 6;
    localparam int OUT_CNT  = 4;
    localparam int BASE_B0  = HIDDEN1 * IN_CNT;
    localparam int BASE_W2  = BASE_B0 + HIDDEN1;
    localparam int BASE_B2  = BASE_W2 + HIDDEN2 * HIDDEN1;
    localparam int BASE_WA  = BASE_B2 + HIDDEN2;
    localparam int BASE_BA  = BASE_WA + OUT_CNT * HIDDEN2;
    localparam int LAYOUT   = BASE_BA + OUT_CNT;
    localparam int ADDR_MAX = (LAYOUT > WEIGHT_DEPTH) ? LAYOUT : WEIGHT_DEPTH;
    localparam int FW       = $clog2(ADDR_MAX + 1);
    localparam int WA       = $clog2(WEIGHT_DEPTH);
    localparam int H1A      = (HIDDEN1 > 1) ? $clog2(HIDDEN1) : 1;
    localparam int H2A      = (HIDDEN2 > 1) ? $clog2(HIDDEN2) : 1;
    localparam int KMAX0    = (HIDDEN1 > HIDDEN2) ? HIDDEN1 : HIDDEN2;
    localparam int KMAX     = (KMAX0 > IN_CNT) ? KMAX0 : IN_CNT;
    localparam int KCW      = $clog2(KMAX + 1);
    localparam int NMAX     = (KMAX0 > OUT_CNT) ? KMAX0 : OUT_CNT;
    localparam int NCW      = $clog2(NMAX);
    localparam int ACCW     = 33 + $clog2(KMAX + 2);
    localparam int BW       = $clog2(TANH_TABLE_DEPTH);
    localparam int PW       = 15 + $clog2(TANH_TABLE_DEPTH + 1);

    typedef logic signed [15:0] tanh_rom_t [TANH_TABLE_DEPTH];

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t rom;
        for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
            rom[i] = tanh_entry(i, TANH_TABLE_DEPTH);
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAC   = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_RND   = 8'b0000_1000,
        S_BIN   = 8'b0001_0000,
        S_LOOK  = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              layer_reg, layer_next;
    logic [KCW-1:0]          k_reg, k_next;
    logic [NCW-1:0]          n_reg, n_next;
    logic [FW-1:0]           wptr_reg, wptr_next;
    logic [FW-1:0]           bptr_reg, bptr_next;
    logic                    p1_reg, p2_reg;
    logic                    bias_p1_reg, oob_p1_reg;
    logic [2:0]              sel_p1_reg;
    logic signed [15:0]      obs_reg [IN_CNT];
    logic signed [31:0]      prod_reg;
    logic signed [ACCW-1:0]  acc_reg, acc_next;
    logic signed [15:0]      x_reg;
    logic                    lo_reg, hi_reg;
    logic [BW-1:0]           bin_reg;
    logic signed [15:0]      th_reg;
    logic [12:0]             act_reg [OUT_CNT];
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;

    logic                    req_fire, wr_fire, issue;
    logic [KCW-1:0]          cur_k;
    logic [NCW-1:0]          cur_last;
    logic [FW-1:0]           rd_addr;
    logic [KCW-1:0]          hk;
    logic [15:0]             w_rdata, h1_rdata, h2_rdata;
    logic signed [15:0]      w_eff, m_in;
    logic signed [ACCW-1:0]  rnd_sum, rnd_shift;
    logic [PW-1:0]           bin_prod;
    logic [14:0]             u_off;
    logic                    h1_we, h2_we, rsp_load;

    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32767);
    localparam logic signed [ACCW-1:0] SAT_LO = -ACCW'(32768);

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign wr_fire   = req_fire && (req_data.op == OP_WRITE)
                       && (32'(req_data.weight_index) < WEIGHT_DEPTH);
    assign issue     = (state_reg == S_MAC);

    // Per-layer fan-in and neuron count
    always_comb
    begin
        case (layer_reg)
            LAYER_ONE: begin
                cur_k    = KCW'(IN_CNT);
                cur_last = NCW'(HIDDEN1 - 1);
            end
            LAYER_TWO: begin
                cur_k    = KCW'(HIDDEN1);
                cur_last = NCW'(HIDDEN2 - 1);
            end
            default: begin
                cur_k    = KCW'(HIDDEN2);
                cur_last = NCW'(OUT_CNT - 1);
            end
        endcase
    end

    assign hk      = k_reg - KCW'(1);
    assign rd_addr = (k_reg == '0) ? bptr_reg : wptr_reg;

    // Memories
    mlpi_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wmem (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (WA'(req_data.weight_index)),
        .wdata (req_data.weight_value),
        .raddr (rd_addr[WA-1:0]),
        .rdata (w_rdata)
    );

    assign h1_we = (state_reg == S_WB) && (layer_reg == LAYER_ONE);
    assign h2_we = (state_reg == S_WB) && (layer_reg == LAYER_TWO);

    mlpi_ram #(.WIDTH(16), .DEPTH(HIDDEN1)) u_h1 (
        .clk   (clk),
        .we    (h1_we),
        .waddr (H1A'(n_reg)),
        .wdata (th_reg),
        .raddr (H1A'(hk)),
        .rdata (h1_rdata)
    );

    mlpi_ram #(.WIDTH(16), .DEPTH(HIDDEN2)) u_h2 (
        .clk   (clk),
        .we    (h2_we),
        .waddr (H2A'(n_reg)),
        .wdata (th_reg),
        .raddr (H2A'(hk)),
        .rdata (h2_rdata)
    );

    // Multiplier operands; bias is scaled by one in Q4.12
    always_comb
    begin
        w_eff = oob_p1_reg ? 16'sd0 : $signed(w_rdata);
        if (bias_p1_reg)
            m_in = 16'(Q_ONE);
        else if (layer_reg == LAYER_ONE)
            m_in = obs_reg[sel_p1_reg];
        else if (layer_reg == LAYER_TWO)
            m_in = $signed(h1_rdata);
        else
            m_in = $signed(h2_rdata);
    end

    always_comb
    begin
        if (issue && (k_reg == '0))
            acc_next = '0;
        else if (p2_reg)
            acc_next = acc_reg + ACCW'(prod_reg);
        else
            acc_next = acc_reg;
    end

    // Rounding and table index
    assign rnd_sum   = acc_reg + ACCW'(2048);
    assign rnd_shift = rnd_sum >>> 12;
    assign u_off     = 15'(x_reg + 16'sd16384);
    assign bin_prod  = PW'(u_off) * PW'(TANH_TABLE_DEPTH);

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        wptr_next  = wptr_reg;
        bptr_next  = bptr_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_fire && (req_data.op == OP_INFER))
                begin
                    state_next = S_MAC;
                    layer_next = LAYER_ONE;
                    k_next     = '0;
                    n_next     = '0;
                    wptr_next  = '0;
                    bptr_next  = FW'(BASE_B0);
                end
            end
            S_MAC: begin
                if (k_reg == '0)
                    bptr_next = bptr_reg + FW'(1);
                else
                    wptr_next = wptr_reg + FW'(1);
                if (k_reg == cur_k)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + KCW'(1);
                end
            end
            S_DRAIN: begin
                if (!p1_reg && !p2_reg)
                    state_next = S_RND;
            end
            S_RND: begin
                state_next = S_BIN;
            end
            S_BIN, S_WB: begin
                if ((state_reg == S_BIN) && (layer_reg != LAYER_OUT))
                    state_next = S_LOOK;
                else if (n_reg != cur_last)
                begin
                    n_next     = n_reg + NCW'(1);
                    state_next = S_MAC;
                end
                else if (layer_reg == LAYER_ONE)
                begin
                    layer_next = LAYER_TWO;
                    n_next     = '0;
                    wptr_next  = FW'(BASE_W2);
                    bptr_next  = FW'(BASE_B2);
                    state_next = S_MAC;
                end
                else if (layer_reg == LAYER_TWO)
                begin
                    layer_next = LAYER_OUT;
                    n_next     = '0;
                    wptr_next  = FW'(BASE_WA);
                    bptr_next  = FW'(BASE_BA);
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOOK: begin
                state_next = S_WB;
            end
            S_DONE: begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layer_reg     <= LAYER_ONE;
            k_reg         <= '0;
            n_reg         <= '0;
            wptr_reg      <= '0;
            bptr_reg      <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            wptr_reg  <= wptr_next;
            bptr_reg  <= bptr_next;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            obs_reg[0] <= req_data.obs_0;
            obs_reg[1] <= req_data.obs_1;
            obs_reg[2] <= req_data.obs_2;
            obs_reg[3] <= req_data.obs_3;
            obs_reg[4] <= req_data.obs_4;
            obs_reg[5] <= req_data.obs_5;
        end
        bias_p1_reg <= (k_reg == '0);
        oob_p1_reg  <= (32'(rd_addr) >= WEIGHT_DEPTH);
        sel_p1_reg  <= hk[2:0];
        prod_reg    <= w_eff * m_in;
        acc_reg     <= acc_next;

        // Round to Q4.12 and saturate
        if (state_reg == S_RND)
        begin
            if (rnd_shift > SAT_HI)
                x_reg <= 16'sd32767;
            else if (rnd_shift < SAT_LO)
                x_reg <= -16'sd32768;
            else
                x_reg <= 16'(rnd_shift);
        end

        // Output clamp or tanh bin
        if (state_reg == S_BIN)
        begin
            lo_reg  <= (x_reg < -16'sd16384);
            hi_reg  <= (x_reg >= 16'sd16384);
            bin_reg <= bin_prod[15 +: BW];
            if (layer_reg == LAYER_OUT)
            begin
                if (x_reg < 16'sd0)
                    act_reg[n_reg[1:0]] <= 13'd0;
                else if (x_reg > 16'sd4096)
                    act_reg[n_reg[1:0]] <= 13'd4096;
                else
                    act_reg[n_reg[1:0]] <= x_reg[12:0];
            end
        end

        if (state_reg == S_LOOK)
        begin
            if (lo_reg)
                th_reg <= -16'sd4096;
            else if (hi_reg)
                th_reg <= 16'sd4096;
            else
                th_reg <= TANH_ROM[bin_reg];
        end

        if (rsp_load)
        begin
            rsp_reg.action_0 <= act_reg[0];
            rsp_reg.action_1 <= act_reg[1];
            rsp_reg.action_2 <= act_reg[2];
            rsp_reg.action_3 <= act_reg[3];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // MAC pipeline is empty before rounding starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND) |-> (!p1_reg && !p2_reg))
        else $error("MAC pipeline not drained at rounding");

    // Products only flow while a neuron is being summed
    assert property (@(posedge clk) disable iff (!rst_n)
        p2_reg |-> ((state_reg == S_MAC) || (state_reg == S_DRAIN)))
        else $error("product outside accumulation");

    // A pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("stalled result lost");

    // Hidden buffers are written only in the hidden layers
    assert property (@(posedge clk) disable iff (!rst_n)
        !(h1_we && h2_we) && !(h1_we && (layer_reg == LAYER_OUT)))
        else $error("bad hidden buffer write");

endmodule
